// ===== hw/rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the checker file lpam_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/lpam_pkg.sv =====
// lpam_pkg: widths and constants for the largest-prime search block.
// No dependencies.
package lpam_pkg;

  localparam int LimitW = 32;  // signed request field
  localparam int PrimeW = 31;  // result field, also candidate width
  localparam int DivW   = 16;  // trial divisor never exceeds ~46350
  localparam int StepW  = $clog2(PrimeW);

  localparam logic [PrimeW-1:0] SmallPrime = PrimeW'(2);
  localparam logic [PrimeW-1:0] OddFloor   = PrimeW'(3);
  localparam logic [DivW-1:0]   DivThree   = DivW'(3);
  localparam logic [DivW-1:0]   DivFirst   = DivW'(5);
  localparam logic [DivW-1:0]   DivPairGap = DivW'(2);
  localparam logic [DivW-1:0]   DivStride  = DivW'(6);

endpackage

// ===== hw/rtl/largest_prime_at_most.sv =====
// largest_prime_at_most: returns the largest prime not above a signed limit.
// Depends on lpam_pkg.
//
// Usage:
//   Request channel: limit (32-bit signed) with in_valid / in_ready.
//   Result channel:  prime (31-bit) with out_valid / out_ready.
//   A limit of 2 or less (negatives included) answers 2. Otherwise the odd
//   value at or below the limit is tested, then odd values downward, until a
//   prime is found.
//   The block takes one request at a time; in_ready is low while it searches.
//   All divisions go through one restoring divider, one quotient bit per
//   cycle; the quotient gives the bound d <= cand / d and the remainder the
//   divisibility test. Each candidate above 3 is first divided by 3, then by
//   each divisor pair (d, d+2) with d = 5, 11, 17 and upward in steps of 6
//   while d <= cand / d; a division by a d that fails this bound ends the loop
//   with a prime. A small limit skips the search and goes straight to S_FIN.
//   The result sits in an output register. If the receiver stalls, a finished
//   search waits in its final state until that register frees; a new request
//   is taken only after the result has been loaded.
//   Reset (synchronous, active high) returns to idle and drops out_valid.
module largest_prime_at_most (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [lpam_pkg::LimitW-1:0] limit,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic        [lpam_pkg::PrimeW-1:0] prime
);
  import lpam_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for a request
    S_CAND,  // start testing current candidate
    S_DIV,   // divider iterating
    S_EVAL,  // act on quotient and remainder
    S_FIN    // load result register
  } state_t;

  typedef enum logic [1:0] {
    M_THREE,
    M_D,
    M_D2
  } mode_t;

  state_t              state;
  mode_t               mode;
  logic [PrimeW-1:0]   cand;     // current odd candidate
  logic [PrimeW-1:0]   res;      // answer waiting for the output register
  logic [DivW-1:0]     tdiv;     // trial divisor base d
  logic [PrimeW-1:0]   dvd;      // dividend in, quotient out
  logic [DivW-1:0]     dsr;      // current divisor
  logic [DivW-1:0]     rem;      // partial remainder, always < dsr
  logic [StepW-1:0]    step;

  // Shared divider: one restoring step per cycle.
  logic [DivW:0]       div_trial;
  logic                div_ge;
  logic [DivW-1:0]     rem_next;

  always_comb begin
    div_trial = {rem, dvd[PrimeW-1]};
    div_ge    = (div_trial >= {1'b0, dsr});
    if (div_ge) begin
      rem_next = DivW'(div_trial - {1'b0, dsr});
    end else begin
      rem_next = div_trial[DivW-1:0];
    end
  end

  logic small_limit;
  assign small_limit = limit[LimitW-1] || (limit[PrimeW-1:0] <= SmallPrime);

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a result taken while a new one is ready is replaced in S_FIN
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (small_limit) begin
              res   <= SmallPrime;
              state <= S_FIN;
            end else begin
              // lower an even limit to the odd value below it
              cand  <= limit[0] ? limit[PrimeW-1:0] : limit[PrimeW-1:0] - PrimeW'(1);
              state <= S_CAND;
            end
          end
        end

        S_CAND: begin
          if (cand == OddFloor) begin
            res   <= cand;
            state <= S_FIN;
          end else begin
            mode  <= M_THREE;
            dsr   <= DivThree;
            dvd   <= cand;
            rem   <= '0;
            step  <= '0;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[PrimeW-2:0], div_ge};
          step <= step + StepW'(1);
          if (step == StepW'(PrimeW - 1)) begin
            state <= S_EVAL;
          end
        end

        S_EVAL: begin
          if ((mode == M_D) && (PrimeW'(tdiv) > dvd)) begin
            // d above cand / d: no divisor left, prime
            res   <= cand;
            state <= S_FIN;
          end else if (rem == '0) begin
            // composite: next odd value down
            cand  <= cand - PrimeW'(2);
            state <= S_CAND;
          end else begin
            case (mode)
              M_THREE: begin
                mode  <= M_D;
                tdiv  <= DivFirst;
                dsr   <= DivFirst;
                dvd   <= cand;
                rem   <= '0;
                step  <= '0;
                state <= S_DIV;
              end
              M_D: begin
                mode  <= M_D2;
                dsr   <= tdiv + DivPairGap;
                dvd   <= cand;
                rem   <= '0;
                step  <= '0;
                state <= S_DIV;
              end
              default: begin
                mode  <= M_D;
                tdiv  <= tdiv + DivStride;
                dsr   <= tdiv + DivStride;
                dvd   <= cand;
                rem   <= '0;
                step  <= '0;
                state <= S_DIV;
              end
            endcase
          end
        end

        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            prime     <= res;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lpam_checker.sv =====
// lpam_checker: port-level assertions for largest_prime_at_most, plus bind.
// Depends on assert_macros.svh and lpam_pkg.
`include "assert_macros.svh"

module lpam_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lpam_pkg::PrimeW-1:0]   prime
);
  import lpam_pkg::*;

  // stalled result holds its value
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(prime))

  // a result is never below 2
  `CHK_IMPLIES(a_prime_min, clk, rst, out_valid, prime >= SmallPrime)

  // a result is 2 or odd
  `CHK_IMPLIES(a_prime_odd, clk, rst, out_valid, prime[0] || (prime == SmallPrime))

  // one request at a time: busy right after accepting
  `CHK_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind largest_prime_at_most lpam_checker u_lpam_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .prime     (prime)
);

// ===== tb/sv/largest_prime_at_most_tb.sv =====
// largest_prime_at_most_tb: self-checking bench for the largest-prime search block.
// Depends on lpam_pkg and largest_prime_at_most. It predicts each answer by
// trial division and checks every result in order.
module largest_prime_at_most_tb;
  import lpam_pkg::*;

  localparam int          IdlePct     = 31;          // chance of a gap on either side
  localparam int          RandomItems = 82;
  localparam int          CalmFirst   = 50;          // requests/results with no gaps
  localparam int          CalmLast    = 70;
  localparam int          HoldAt      = 20;          // result count that starts the long stall
  localparam int          HoldCycles  = 4000;
  localparam int          TailCycles  = 200;
  localparam int unsigned CycleLimit  = 20_000_000;

  logic clk;
  logic rst;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [LimitW-1:0] limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PrimeW-1:0] prime;

  largest_prime_at_most u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .limit    (limit),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .prime    (prime)
  );

  // Limits waiting to be offered, and primes owed by the block, oldest first.
  logic signed [LimitW-1:0] pending_limits[$];
  logic [PrimeW-1:0]        owed_primes[$];

  int          err_count = 0;
  int          sent = 0;
  int          results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  // Search state, mirrored for completeness: last odd value tried and the
  // last divisor base. A small limit leaves both untouched.
  logic [31:0] search_cand = '0;
  logic [31:0] search_div  = '0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Primality of an odd v >= 3: reject multiples of 3, then try d and d+2 for
  // d = 5, 11, 17, ... as long as d <= v / d.
  function automatic bit odd_is_prime(input logic [31:0] v);
    logic [31:0] d;
    if (v == 32'd3)
      return 1'b1;
    if (v % 32'd3 == 0)
      return 1'b0;
    for (d = 32'd5; d <= v / d; d += 32'd6) begin
      search_div = d;
      if (v % d == 0 || v % (d + 32'd2) == 0)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  // Largest prime <= lim; anything at or below 2 (negatives too) answers 2.
  function automatic logic [PrimeW-1:0] largest_prime_upto(
    input logic signed [LimitW-1:0] lim
  );
    logic [31:0] c;
    if (lim <= 2)
      return SmallPrime;
    c = lim;
    if (!c[0])
      c = c - 32'd1;
    forever begin
      search_cand = c;
      if (c <= 32'd3 || odd_is_prime(c))
        break;
      c = c - 32'd2;
    end
    return c[PrimeW-1:0];
  endfunction

  // Random limits: mostly small so the serial divider stays quick, a share of
  // negatives for the sign and upper bits, a few up to 2^20.
  function automatic logic signed [LimitW-1:0] pick_limit();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 25)
      return $signed($urandom() | 32'h8000_0000);
    else if (roll < 40)
      return $signed(32'($urandom_range(40, 0)));
    else if (roll < 88)
      return $signed(32'($urandom_range(20000, 0)));
    else
      return $signed(32'($urandom_range(1 << 20, 0)));
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, stimulus
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    // Directed: sign extremes, the small-limit band, odd and even limits,
    // squares of the trial divisors (d*d == v and (d+2)^2 == v), a large even
    // limit, and the largest limit, which is itself prime. A small limit right
    // after the big search checks that the search state does not leak.
    pending_limits.push_back(32'sh8000_0000);
    pending_limits.push_back(-32'sd1);
    pending_limits.push_back(-32'sd7);
    pending_limits.push_back(32'sd0);
    pending_limits.push_back(32'sd1);
    pending_limits.push_back(32'sd2);
    pending_limits.push_back(32'sd3);
    pending_limits.push_back(32'sd4);
    pending_limits.push_back(32'sd5);
    pending_limits.push_back(32'sd6);
    pending_limits.push_back(32'sd9);
    pending_limits.push_back(32'sd24);
    pending_limits.push_back(32'sd25);
    pending_limits.push_back(32'sd49);
    pending_limits.push_back(32'sd121);
    pending_limits.push_back(32'sd65536);
    pending_limits.push_back(32'sd1000000);
    pending_limits.push_back(32'sh7FFF_FFFF);
    pending_limits.push_back(32'sd2);
    for (int i = 0; i < RandomItems; i++)
      pending_limits.push_back(pick_limit());
  end

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // The answer is predicted at the edge where the request is taken. A new
  // limit goes out only when the channel is empty or its request is taken at
  // this edge, so in_valid holds steady until accepted.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_primes.push_back(largest_prime_upto(limit));
        sent <= sent + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_limits.size() != 0 &&
            ((sent >= CalmFirst && sent < CalmLast) ||
             $urandom_range(99, 0) >= IdlePct)) begin
          in_valid <= 1'b1;
          limit    <= pending_limits.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: long hold-off once, so the block finishes a search, parks the
  // result, takes the next request and then stalls its input behind it.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == HoldAt) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor: compare each taken result with the oldest owed prime.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_primes.size() == 0) begin
          $error("unexpected result: prime=%0d", prime);
          err_count++;
        end else begin
          logic [PrimeW-1:0] want;
          want = owed_primes.pop_front();
          if (prime !== want) begin
            $error("prime mismatch: expected %0d, actual %0d", want, prime);
            err_count++;
          end
        end
        results_seen <= results_seen + 1;
      end
      out_ready <= (hold_left == 0) &&
                   ((results_seen >= CalmFirst && results_seen < CalmLast) ||
                    $urandom_range(99, 0) >= IdlePct);
    end
  end

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    @(negedge rst);
    while (pending_limits.size() != 0 || in_valid || owed_primes.size() != 0)
      @(posedge clk);
    // Quiet tail: any stray result here is flagged by the monitor.
    repeat (TailCycles) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== largest_prime_at_most.f =====
+incdir+hw/rtl
hw/rtl/lpam_pkg.sv
hw/rtl/largest_prime_at_most.sv
hw/rtl/lpam_checker.sv
tb/sv/largest_prime_at_most_tb.sv
